// ===== hw/rtl/dtq_pkg.sv =====
package dtq_pkg;

	localparam int TIMER_SLOTS   = 32;
	localparam int HANDLE_BITS   = 16;
	localparam int MAX_RESULTS   = 32;
	localparam int TIME_BITS     = 48;
	localparam int DELAY_BITS    = 31;
	localparam int PORT_HANDLE_BITS = 16;
	localparam int SLOT_IDX_BITS = $clog2(TIMER_SLOTS);
	localparam int CNT_BITS      = $clog2(TIMER_SLOTS + 1);
	localparam int FIRE_BITS     = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_SHIFT = 2'd2;

	localparam logic STATUS_FIRED = 1'b0;
	localparam logic STATUS_FULL  = 1'b1;

	typedef struct packed {
		logic [1:0]                    req_type;
		logic [DELAY_BITS-1:0]         delay_ms;
		logic [PORT_HANDLE_BITS-1:0]   handle;
		logic [TIME_BITS-1:0]          now_ms;
		logic signed [TIME_BITS-1:0]   time_shift;
	} req_t;

	typedef struct packed {
		logic [PORT_HANDLE_BITS-1:0] fired_handle;
		logic                        status;
		logic                        is_last;
	} resp_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]   deadline;
		logic [HANDLE_BITS-1:0] hnd;
	} entry_t;

	typedef enum logic [2:0] {
		RD_HEAD  = 3'd0,
		RD_IDX   = 3'd1,
		RD_NEXT  = 3'd2,
		RD_PREV  = 3'd3,
		RD_PREV2 = 3'd4
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NEW     = 2'd0,
		WR_MOVE    = 2'd1,
		WR_SHIFTED = 2'd2
	} wr_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD     = 3'd0,
		IDX_LOAD_CNT = 3'd1,
		IDX_CLEAR    = 3'd2,
		IDX_DEC      = 3'd3,
		IDX_INC      = 3'd4
	} idx_op_t;

	typedef enum logic [1:0] {
		EMIT_MORE   = 2'd0,
		EMIT_LAST   = 2'd1,
		EMIT_REJECT = 2'd2
	} emit_kind_t;

	typedef struct packed {
		logic       accept;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_en;
		wr_sel_t    wr_sel;
		idx_op_t    idx_op;
		logic       push;
		logic       pop;
		logic       fire_clr;
		logic       emit;
		emit_kind_t emit_kind;
	} dtq_cmd_t;

	typedef struct packed {
		logic full;
		logic cnt_zero;
		logic idx_zero;
		logic idx_one;
		logic idx_last;
		logic ge_new;
		logic le_now;
		logic fire_max;
		logic out_free;
	} dtq_stat_t;

endpackage

// ===== hw/rtl/dtq_datapath.sv =====
module dtq_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  dtq_pkg::req_t    req,
	input  dtq_pkg::dtq_cmd_t cmd,
	output dtq_pkg::dtq_stat_t stat,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dtq_pkg::resp_t   rsp
);
	import dtq_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	entry_t                  mem_q [TIMER_SLOTS];
	entry_t                  rd_q;
	entry_t                  wdata;
	logic [TIME_BITS-1:0]    cur_q;
	logic [TIME_BITS-1:0]    new_dl_q;
	logic [HANDLE_BITS-1:0]  new_hnd_q;
	logic [TIME_BITS-1:0]    shift_q;
	logic [HANDLE_BITS-1:0]  pend_q;
	logic [SLOT_IDX_BITS-1:0] head_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [CNT_BITS-1:0]     idx_q;
	logic [FIRE_BITS-1:0]    fcnt_q;
	logic                    out_valid_q;
	resp_t                   out_q;
	logic [CNT_BITS-1:0]     rd_log;
	logic [SLOT_IDX_BITS-1:0] rd_addr;
	logic [SLOT_IDX_BITS-1:0] wr_addr;
	logic [TIME_BITS:0]      add_sum;
	logic [TIME_BITS-1:0]    add_dl;
	logic [TIME_BITS+1:0]    sh_sum;
	logic [TIME_BITS-1:0]    sh_dl;
	logic                    out_free;

	function automatic logic [SLOT_IDX_BITS-1:0] slot_addr(
		input logic [SLOT_IDX_BITS-1:0] head,
		input logic [CNT_BITS-1:0]      la
	);
		logic [CNT_BITS:0] sum;
		sum = (CNT_BITS+1)'(head) + (CNT_BITS+1)'(la);
		if (sum >= (CNT_BITS+1)'(TIMER_SLOTS)) begin
			sum = sum - (CNT_BITS+1)'(TIMER_SLOTS);
		end
		return SLOT_IDX_BITS'(sum);
	endfunction

	always_comb begin
		case (cmd.rd_sel)
			RD_HEAD:  rd_log = '0;
			RD_IDX:   rd_log = idx_q;
			RD_NEXT:  rd_log = idx_q + CNT_BITS'(1);
			RD_PREV:  rd_log = idx_q - CNT_BITS'(1);
			RD_PREV2: rd_log = idx_q - CNT_BITS'(2);
			default:  rd_log = '0;
		endcase
	end

	assign rd_addr = slot_addr(head_q, rd_log);
	assign wr_addr = slot_addr(head_q, idx_q);

	assign add_sum = (TIME_BITS+1)'(cur_q) + (TIME_BITS+1)'(req.delay_ms);
	assign add_dl  = add_sum[TIME_BITS] ? TIME_MAX : add_sum[TIME_BITS-1:0];

	assign sh_sum = (TIME_BITS+2)'(rd_q.deadline) + {{2{shift_q[TIME_BITS-1]}}, shift_q};
	always_comb begin
		if (sh_sum[TIME_BITS+1]) begin
			sh_dl = '0;
		end else if (sh_sum[TIME_BITS]) begin
			sh_dl = TIME_MAX;
		end else begin
			sh_dl = sh_sum[TIME_BITS-1:0];
		end
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_NEW:     wdata = '{deadline: new_dl_q, hnd: new_hnd_q};
			WR_MOVE:    wdata = rd_q;
			WR_SHIFTED: wdata = '{deadline: sh_dl, hnd: rd_q.hnd};
			default:    wdata = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			new_dl_q  <= add_dl;
			new_hnd_q <= HANDLE_BITS'(req.handle);
			shift_q   <= req.time_shift;
		end
		if (cmd.pop) begin
			pend_q <= rd_q.hnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			head_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			fcnt_q <= '0;
		end else begin
			if (cmd.accept && req.req_type == REQ_TICK) begin
				cur_q <= req.now_ms;
			end
			case (cmd.idx_op)
				IDX_HOLD:     idx_q <= idx_q;
				IDX_LOAD_CNT: idx_q <= cnt_q;
				IDX_CLEAR:    idx_q <= '0;
				IDX_DEC:      idx_q <= idx_q - CNT_BITS'(1);
				IDX_INC:      idx_q <= idx_q + CNT_BITS'(1);
				default:      idx_q <= idx_q;
			endcase
			if (cmd.push) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			if (cmd.fire_clr) begin
				fcnt_q <= '0;
			end
			if (cmd.pop) begin
				cnt_q  <= cnt_q - CNT_BITS'(1);
				fcnt_q <= fcnt_q + FIRE_BITS'(1);
				if (head_q == SLOT_IDX_BITS'(TIMER_SLOTS - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + SLOT_IDX_BITS'(1);
				end
			end
		end
	end

	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_kind)
				EMIT_MORE:   out_q <= '{fired_handle: PORT_HANDLE_BITS'(pend_q),
					status: STATUS_FIRED, is_last: 1'b0};
				EMIT_LAST:   out_q <= '{fired_handle: PORT_HANDLE_BITS'(pend_q),
					status: STATUS_FIRED, is_last: 1'b1};
				EMIT_REJECT: out_q <= '{fired_handle: '0, status: STATUS_FULL, is_last: 1'b1};
				default:     out_q <= '{fired_handle: '0, status: STATUS_FULL, is_last: 1'b1};
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign stat.full     = (cnt_q == CNT_BITS'(TIMER_SLOTS));
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.idx_zero = (idx_q == '0);
	assign stat.idx_one  = (idx_q == CNT_BITS'(1));
	assign stat.idx_last = ((idx_q + CNT_BITS'(1)) == cnt_q);
	assign stat.ge_new   = (rd_q.deadline >= new_dl_q);
	assign stat.le_now   = (rd_q.deadline <= cur_q);
	assign stat.fire_max = (fcnt_q == FIRE_BITS'(MAX_RESULTS));
	assign stat.out_free = out_free;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(TIMER_SLOTS))
		else $error("Timer count exceeds the table size.");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> cnt_q != CNT_BITS'(TIMER_SLOTS))
		else $error("Timer inserted into a full table.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> cnt_q != '0)
		else $error("Timer removed from an empty table.");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("Result overwritten while still waiting.");

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> fcnt_q < FIRE_BITS'(MAX_RESULTS))
		else $error("Too many timers fired on one tick.");

endmodule

// ===== hw/rtl/dtq_ctrl.sv =====
module dtq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_type,
	output logic               req_stall,
	input  dtq_pkg::dtq_stat_t stat,
	output dtq_pkg::dtq_cmd_t  cmd
);
	import dtq_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_ADD_RD  = 8'b0000_0010,
		S_ADD_CMP = 8'b0000_0100,
		S_REJ     = 8'b0000_1000,
		S_TK_RD   = 8'b0001_0000,
		S_TK_CMP  = 8'b0010_0000,
		S_SH_RD   = 8'b0100_0000,
		S_SH_WR   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pend_q;
	logic   pend_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '{accept: 1'b0, rd_en: 1'b0, rd_sel: RD_HEAD, wr_en: 1'b0,
			wr_sel: WR_NEW, idx_op: IDX_HOLD, push: 1'b0, pop: 1'b0,
			fire_clr: 1'b0, emit: 1'b0, emit_kind: EMIT_LAST};
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (req_type)
						REQ_ADD: begin
							if (stat.full) begin
								state_d = S_REJ;
							end else begin
								cmd.idx_op = IDX_LOAD_CNT;
								state_d    = S_ADD_RD;
							end
						end
						REQ_TICK: begin
							cmd.fire_clr = 1'b1;
							pend_d       = 1'b0;
							state_d      = S_TK_RD;
						end
						REQ_SHIFT: begin
							cmd.idx_op = IDX_CLEAR;
							state_d    = S_SH_RD;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ADD_RD: begin
				if (stat.idx_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_NEW;
					cmd.push   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_d    = S_ADD_CMP;
				end
			end
			S_ADD_CMP: begin
				cmd.wr_en = 1'b1;
				if (stat.ge_new) begin
					cmd.wr_sel = WR_MOVE;
					cmd.idx_op = IDX_DEC;
					if (stat.idx_one) begin
						state_d = S_ADD_RD;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_PREV2;
					end
				end else begin
					cmd.wr_sel = WR_NEW;
					cmd.push   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_REJ: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = EMIT_REJECT;
					state_d       = S_IDLE;
				end
			end
			S_TK_RD: begin
				if (stat.out_free) begin
					if (!stat.cnt_zero && !stat.fire_max) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_HEAD;
						state_d    = S_TK_CMP;
					end else begin
						cmd.emit      = pend_q;
						cmd.emit_kind = EMIT_LAST;
						pend_d        = 1'b0;
						state_d       = S_IDLE;
					end
				end
			end
			S_TK_CMP: begin
				if (stat.out_free) begin
					if (stat.le_now) begin
						cmd.pop       = 1'b1;
						cmd.emit      = pend_q;
						cmd.emit_kind = EMIT_MORE;
						pend_d        = 1'b1;
						state_d       = S_TK_RD;
					end else begin
						cmd.emit      = pend_q;
						cmd.emit_kind = EMIT_LAST;
						pend_d        = 1'b0;
						state_d       = S_IDLE;
					end
				end
			end
			S_SH_RD: begin
				if (stat.cnt_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFTED;
				cmd.idx_op = IDX_INC;
				if (stat.idx_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_q)
		else $error("A fired timer was left undelivered.");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> state_q == S_IDLE)
		else $error("Item taken while busy.");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> cmd.wr_en && !cmd.pop)
		else $error("Insert without a table write.");

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// Pending timers are held in a table sorted by deadline, kept as a ring in a single memory with
// one write and one registered read port, so each step handles one entry at a time. An add
// into a non-full table moves each stored timer whose deadline is not earlier than the new one
// up by one slot, then writes the new timer. An add into a full table gives one rejection item.
// A tick fires at most 32 timers, earliest first and newest first among equal deadlines, with
// is_last on the final one; a tick that fires nothing gives no item. A deadline shift rewrites
// each stored timer in turn. Items are taken one at a time; stall stays high until the memory
// pass of the current item has finished, while a finished result may still be waiting in the
// output register.
module deadline_timer_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dtq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dtq_pkg::resp_t rsp
);
	import dtq_pkg::*;

	dtq_cmd_t  cmd;
	dtq_stat_t stat;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dtq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== verif/tb_deadline_timer_queue.sv =====
module tb_deadline_timer_queue;
	import dtq_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [PORT_HANDLE_BITS-1:0] HANDLE_MASK = (HANDLE_BITS >= PORT_HANDLE_BITS) ?
		'1 : PORT_HANDLE_BITS'((64'd1 << HANDLE_BITS) - 64'd1);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_PER_PHASE = 45;
	localparam int BY_MODEL = -1;

	typedef struct {
		req_t  r;
		int    want;
		resp_t res;
	} stim_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	req_t  req = '0;
	logic  req_stall;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	resp_t rsp;

	logic [TIME_BITS-1:0]        clock_now = '0;
	logic [TIME_BITS-1:0]        timer_deadline [TIMER_SLOTS];
	logic [PORT_HANDLE_BITS-1:0] timer_handle [TIMER_SLOTS];
	int                          timer_count = 0;

	resp_t pending_rsp [$];
	int    mismatches = 0;
	int    cycle_cnt = 0;
	int    snd_idle_pct = 0;
	int    rcv_idle_pct = 0;
	int    hold_ticket = 0;
	int    hold_served = 0;
	int    hold_left = 0;

	deadline_timer_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [TIME_BITS-1:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic req_t mk(logic [1:0] kind, logic [DELAY_BITS-1:0] delay,
			logic [PORT_HANDLE_BITS-1:0] hnd, logic [TIME_BITS-1:0] now,
			logic [TIME_BITS-1:0] shift);
		req_t r;
		r.req_type   = kind;
		r.delay_ms   = delay;
		r.handle     = hnd;
		r.now_ms     = now;
		r.time_shift = shift;
		return r;
	endfunction

	// Timers are kept earliest deadline first; a new timer goes ahead of equal deadlines.
	function automatic void predict_timers(input req_t r, ref resp_t fired[$]);
		logic [TIME_BITS:0]          sum;
		logic [TIME_BITS-1:0]        dl;
		logic signed [TIME_BITS+1:0] moved;
		int                          pos;
		int                          n;
		case (r.req_type)
			REQ_ADD: begin
				if (timer_count >= TIMER_SLOTS) begin
					fired.push_back('{fired_handle: '0, status: STATUS_FULL, is_last: 1'b1});
				end else begin
					sum = clock_now + r.delay_ms;
					dl = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
					pos = 0;
					while (pos < timer_count && timer_deadline[pos] < dl)
						pos++;
					for (int i = timer_count; i > pos; i--) begin
						timer_deadline[i] = timer_deadline[i-1];
						timer_handle[i]   = timer_handle[i-1];
					end
					timer_deadline[pos] = dl;
					timer_handle[pos]   = r.handle & HANDLE_MASK;
					timer_count++;
				end
			end
			REQ_TICK: begin
				clock_now = r.now_ms;
				n = 0;
				while (n < timer_count && n < MAX_RESULTS && timer_deadline[n] <= clock_now)
					n++;
				for (int i = 0; i < n; i++)
					fired.push_back('{fired_handle: timer_handle[i], status: STATUS_FIRED,
						is_last: (i == n - 1)});
				for (int i = 0; i + n < timer_count; i++) begin
					timer_deadline[i] = timer_deadline[i+n];
					timer_handle[i]   = timer_handle[i+n];
				end
				timer_count -= n;
			end
			REQ_SHIFT: begin
				for (int i = 0; i < timer_count; i++) begin
					moved = $signed({2'b00, timer_deadline[i]})
						+ $signed({{2{r.time_shift[TIME_BITS-1]}}, r.time_shift});
					if (moved[TIME_BITS+1])
						timer_deadline[i] = '0;
					else if (moved[TIME_BITS])
						timer_deadline[i] = TIME_MAX;
					else
						timer_deadline[i] = moved[TIME_BITS-1:0];
				end
			end
			default: ;
		endcase
	endfunction

	function automatic req_t rand_item();
		req_t r;
		int   pick;
		r = mk(REQ_UNUSED, DELAY_BITS'($urandom), PORT_HANDLE_BITS'($urandom), rand48(),
			rand48());
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.req_type = REQ_ADD;
			if ($urandom_range(0, 9) != 0)
				r.delay_ms = DELAY_BITS'($urandom_range(0, 300));
		end else if (pick < 80) begin
			r.req_type = REQ_TICK;
			case ($urandom_range(0, 9))
				0: ;
				1: r.now_ms = clock_now - $urandom_range(1, 100);
				default: r.now_ms = clock_now + $urandom_range(0, 200);
			endcase
		end else if (pick < 95) begin
			r.req_type = REQ_SHIFT;
			if ($urandom_range(0, 4) != 0)
				r.time_shift = TIME_BITS'(int'($urandom_range(0, 300)) - 150);
		end
		return r;
	endfunction

	task automatic offer_item(input req_t r, input int want, input resp_t typed_res);
		resp_t outs [$];
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		predict_timers(r, outs);
		if (want == BY_MODEL) begin
			foreach (outs[i])
				pending_rsp.push_back(outs[i]);
		end else if (want == 1) begin
			pending_rsp.push_back(typed_res);
		end
	endtask

	// Empties the table, then fills it past capacity and fires everything at once.
	task automatic flood_and_flush();
		req_t r;
		r = rand_item();
		r.req_type = REQ_TICK;
		r.now_ms = TIME_MAX;
		offer_item(r, BY_MODEL, '0);
		r.now_ms = TIME_BITS'($urandom_range(0, 1000));
		offer_item(r, BY_MODEL, '0);
		repeat (TIMER_SLOTS + 2) begin
			r = rand_item();
			r.req_type = REQ_ADD;
			r.delay_ms = DELAY_BITS'($urandom_range(0, 50));
			offer_item(r, BY_MODEL, '0);
		end
		r = rand_item();
		r.req_type = REQ_TICK;
		r.now_ms = clock_now + 1000;
		offer_item(r, BY_MODEL, '0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("result with none expected: fired_handle %h status %b is_last %b",
						rsp.fired_handle, rsp.status, rsp.is_last);
					mismatches++;
				end else begin
					if (rsp.fired_handle !== pending_rsp[0].fired_handle) begin
						$error("fired_handle: expected %h, got %h",
							pending_rsp[0].fired_handle, rsp.fired_handle);
						mismatches++;
					end
					if (rsp.status !== pending_rsp[0].status) begin
						$error("status: expected %b, got %b", pending_rsp[0].status, rsp.status);
						mismatches++;
					end
					if (rsp.is_last !== pending_rsp[0].is_last) begin
						$error("is_last: expected %b, got %b", pending_rsp[0].is_last,
							rsp.is_last);
						mismatches++;
					end
					void'(pending_rsp.pop_front());
				end
			end
			if (hold_ticket != hold_served) begin
				hold_served = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		req_t      r;
		int        n;
		rows = '{
			'{mk(REQ_TICK, 0, 0, 0, 0), 0, '0},
			'{mk(REQ_ADD, 0, 16'hFFFF, 0, 0), 0, '0},
			'{mk(REQ_TICK, 0, 0, 0, 0), 1, '{16'hFFFF, STATUS_FIRED, 1'b1}},
			'{mk(REQ_ADD, 31'h7FFF_FFFF, 16'h0001, 0, 0), 0, '0},
			'{mk(REQ_ADD, 5, 16'h1234, 0, 0), 0, '0},
			'{mk(REQ_ADD, 5, 16'h4321, 0, 0), 0, '0},
			'{mk(REQ_TICK, 0, 0, 5, 0), BY_MODEL, '0},
			'{mk(REQ_SHIFT, 0, 0, 0, 48'h7FFF_FFFF_FFFF), 0, '0},
			'{mk(REQ_TICK, 0, 0, 48'h8000_7FFF_FFFD, 0), 0, '0},
			'{mk(REQ_TICK, 0, 0, TIME_MAX, 0), 1, '{16'h0001, STATUS_FIRED, 1'b1}},
			'{mk(REQ_ADD, 31'h7FFF_FFFF, 16'hA5A5, 0, 0), 0, '0},
			'{mk(REQ_ADD, 0, 16'h5A5A, 0, 0), 0, '0},
			'{mk(REQ_TICK, 0, 0, TIME_MAX, 0), BY_MODEL, '0},
			'{mk(REQ_TICK, 0, 0, 100, 0), 0, '0},
			'{mk(REQ_ADD, 1000, 16'h0F0F, 0, 0), 0, '0},
			'{mk(REQ_SHIFT, 0, 0, 0, 48'h8000_0000_0000), 0, '0},
			'{mk(REQ_TICK, 0, 0, 0, 0), 1, '{16'h0F0F, STATUS_FIRED, 1'b1}},
			'{mk(REQ_UNUSED, '1, '1, '1, '1), 0, '0},
			'{mk(REQ_ADD, 10, 16'h0000, 0, 0), 0, '0},
			'{mk(REQ_SHIFT, 0, 0, 0, 5), 0, '0},
			'{mk(REQ_SHIFT, 0, 0, 0, 48'hFFFF_FFFF_FFFD), 0, '0},
			'{mk(REQ_TICK, 0, 0, 11, 0), BY_MODEL, '0},
			'{mk(REQ_TICK, 0, 0, 12, 0), 1, '{16'h0000, STATUS_FIRED, 1'b1}}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle_pct = 35;
		rcv_idle_pct = 53;
		foreach (rows[i])
			offer_item(rows[i].r, rows[i].want, rows[i].res);
		for (int ph = 0; ph < 3; ph++) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while (pending_rsp.size() != 0);
			snd_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 53 : 0;
			rcv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 35 : 0;
			if (ph == 2)
				hold_ticket++;
			flood_and_flush();
			n = 0;
			while (n < RANDOM_PER_PHASE) begin
				r = rand_item();
				offer_item(r, BY_MODEL, '0);
				if (r.req_type != REQ_UNUSED)
					n++;
			end
		end
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
